@@ hdl/infix_to_postfix_converter_core_macros.svh @@
// Assertion macros for the infix to postfix converter.
// Included by the top level; needs nothing else.
`ifndef INFIX_TO_POSTFIX_CONVERTER_CORE_MACROS_SVH
`define INFIX_TO_POSTFIX_CONVERTER_CORE_MACROS_SVH

// Same-cycle implication, disabled in reset
`define ITP_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled in reset
`define ITP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/itp_pkg.sv @@
// Shared types, constants and helpers of the infix to postfix converter.
// No dependencies.
package itp_pkg;

  // operator characters
  localparam logic [7:0] CH_ADD = 8'h2B;  // '+'
  localparam logic [7:0] CH_SUB = 8'h2D;  // '-'
  localparam logic [7:0] CH_MUL = 8'h2A;  // '*'
  localparam logic [7:0] CH_DIV = 8'h2F;  // '/'

  // depth of the queue between front and back end
  localparam int unsigned QUEUE_DEPTH = 2;

  // operator codes; bit 1 set means high precedence
  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_code_e;

  // back end phase
  typedef enum logic {
    PH_MAIN  = 1'b0,
    PH_FLUSH = 1'b1
  } phase_e;

  // classified item as queued between the two ends
  typedef struct packed {
    logic [7:0] symbol;
    logic       is_op;
    op_code_e   code;
    logic       is_last;
  } entry_t;

  // queue head offered to the back end
  typedef struct packed {
    logic   valid;
    entry_t entry;
  } head_t;

  // back end status, watched by the top level
  typedef struct packed {
    logic [1:0] stack_count;
    phase_e     phase;
  } back_status_t;

  // operator code back to its character
  function automatic logic [7:0] code_char(op_code_e code);
    logic [7:0] ch;
    case (code)
      OP_ADD:  ch = CH_ADD;
      OP_SUB:  ch = CH_SUB;
      OP_MUL:  ch = CH_MUL;
      OP_DIV:  ch = CH_DIV;
      default: ch = CH_ADD;
    endcase
    return ch;
  endfunction

endpackage

@@ hdl/itp_if.sv @@
// Valid/ready channels of the infix to postfix converter.
// No dependencies.
interface itp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] symbol;
  logic       is_last;

  modport source (output valid, output symbol, output is_last, input ready);
  modport sink   (input valid, input symbol, input is_last, output ready);
endinterface

interface itp_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_symbol;
  logic       last_of_run;
  logic       expr_done;

  modport source (output valid, output out_symbol, output last_of_run,
                  output expr_done, input ready);
  modport sink   (input valid, input out_symbol, input last_of_run,
                  input expr_done, output ready);
endinterface

@@ hdl/itp_front.sv @@
// Front end: accepts characters, classifies them and queues them.
// Depends on itp_pkg and itp_in_if.
module itp_front #(
  parameter int unsigned Depth = itp_pkg::QUEUE_DEPTH
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  itp_in_if.sink          in_i,
  output itp_pkg::head_t  head_o,
  input  logic            pop_i
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] Full    = CntW'(Depth);

  itp_pkg::entry_t slot_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  itp_pkg::entry_t in_entry;
  logic            push, pop;

  // classify the incoming character
  always_comb begin
    in_entry.symbol  = in_i.symbol;
    in_entry.is_last = in_i.is_last;
    in_entry.is_op   = 1'b1;
    case (in_i.symbol)
      itp_pkg::CH_ADD: in_entry.code = itp_pkg::OP_ADD;
      itp_pkg::CH_SUB: in_entry.code = itp_pkg::OP_SUB;
      itp_pkg::CH_MUL: in_entry.code = itp_pkg::OP_MUL;
      itp_pkg::CH_DIV: in_entry.code = itp_pkg::OP_DIV;
      default: begin
        in_entry.is_op = 1'b0;
        in_entry.code  = itp_pkg::OP_ADD;
      end
    endcase
  end

  assign in_i.ready = (cnt_q != Full);
  assign push       = in_i.valid && in_i.ready;
  assign pop        = pop_i && (cnt_q != '0);

  // pointer and fill bookkeeping
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + PtrW'(1);
    end
    case ({push, pop})
      2'b10:   cnt_d = cnt_q + CntW'(1);
      2'b01:   cnt_d = cnt_q - CntW'(1);
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // queue storage, no reset
  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= in_entry;
    end
  end

  assign head_o.valid = (cnt_q != '0);
  assign head_o.entry = slot_q[rd_ptr_q];

endmodule

@@ hdl/itp_back.sv @@
// Back end: operator stack, pops, flushes; one result per cycle if ready.
// Depends on itp_pkg and itp_out_if.
module itp_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  itp_pkg::head_t       head_i,
  output logic                 pop_o,
  itp_out_if.source            out_o,
  output itp_pkg::back_status_t status_o
);

  itp_pkg::op_code_e stack_q [2];
  logic [1:0]        cnt_q, cnt_d;
  itp_pkg::phase_e   phase_q, phase_d;

  logic       out_valid_q;
  logic [7:0] out_sym_q;
  logic       out_lor_q, out_done_q;

  logic              can_emit, emit;
  logic [7:0]        emit_sym;
  logic              emit_lor, emit_done;
  logic              push;
  logic              top_idx;
  itp_pkg::op_code_e top_code;
  logic              pop_cond, more_pops, flush;
  itp_pkg::entry_t   cur;

  assign cur      = head_i.entry;
  assign top_idx  = 1'(cnt_q - 2'd1);
  assign top_code = stack_q[top_idx];
  // top binds at least as tightly as the new operator
  assign pop_cond  = (cnt_q != 2'd0) && (top_code[1] >= cur.code[1]);
  assign more_pops = (cnt_q == 2'd2) && (stack_q[0][1] >= cur.code[1]);
  assign flush     = cur.is_last && (cnt_q != 2'd0);
  assign can_emit  = !out_valid_q || out_o.ready;

  // next action of the back end
  always_comb begin
    phase_d   = phase_q;
    cnt_d     = cnt_q;
    emit      = 1'b0;
    emit_sym  = cur.symbol;
    emit_lor  = 1'b0;
    emit_done = 1'b0;
    push      = 1'b0;
    pop_o     = 1'b0;
    case (phase_q)
      itp_pkg::PH_MAIN: begin
        if (head_i.valid) begin
          if (!cur.is_op) begin
            // operand: copy through
            emit      = 1'b1;
            emit_lor  = !flush;
            emit_done = cur.is_last && !flush;
            if (can_emit) begin
              if (flush) begin
                phase_d = itp_pkg::PH_FLUSH;
              end else begin
                pop_o = 1'b1;
              end
            end
          end else if (pop_cond) begin
            // pop a tighter or equal operator
            emit     = 1'b1;
            emit_sym = itp_pkg::code_char(top_code);
            emit_lor = !cur.is_last && !more_pops;
            if (can_emit) begin
              cnt_d = cnt_q - 2'd1;
            end
          end else begin
            // push; a full stack cannot occur here
            if (cnt_q != 2'd2) begin
              push  = 1'b1;
              cnt_d = cnt_q + 2'd1;
            end
            if (cur.is_last) begin
              phase_d = itp_pkg::PH_FLUSH;
            end else begin
              pop_o = 1'b1;
            end
          end
        end
      end
      itp_pkg::PH_FLUSH: begin
        if (cnt_q == 2'd0) begin
          phase_d = itp_pkg::PH_MAIN;
          pop_o   = 1'b1;
        end else begin
          emit      = 1'b1;
          emit_sym  = itp_pkg::code_char(top_code);
          emit_lor  = (cnt_q == 2'd1);
          emit_done = (cnt_q == 2'd1);
          if (can_emit) begin
            cnt_d = cnt_q - 2'd1;
            if (cnt_q == 2'd1) begin
              phase_d = itp_pkg::PH_MAIN;
              pop_o   = 1'b1;
            end
          end
        end
      end
      default: phase_d = itp_pkg::PH_MAIN;
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= itp_pkg::PH_MAIN;
      cnt_q       <= 2'd0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      if (emit && can_emit) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // result payload and stack entries
  always_ff @(posedge clk_i) begin
    if (emit && can_emit) begin
      out_sym_q  <= emit_sym;
      out_lor_q  <= emit_lor;
      out_done_q <= emit_done;
    end
    if (push) begin
      stack_q[cnt_q[0]] <= cur.code;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.out_symbol  = out_sym_q;
  assign out_o.last_of_run = out_lor_q;
  assign out_o.expr_done   = out_done_q;

  assign status_o.stack_count = cnt_q;
  assign status_o.phase       = phase_q;

endmodule

@@ hdl/infix_to_postfix_converter_core.sv @@
// Top level of the infix to postfix converter: front end, queue, back end.
// Depends on itp_pkg, itp_if, itp_front, itp_back and the macro header.
//
// Converts a stream of expression characters (+ - * / as operators, any
// other byte as an operand) into postfix order without parentheses. The
// front end classifies each character into a queue of QueueDepth entries;
// the back end drains it, emitting one result per cycle from its output
// register while the output is ready. An operand is copied through; an
// operator first pops each stacked operator that binds at least as tightly,
// one result each, then pushes itself, and a character marked last then
// flushes the single operator stack. The back end works on one queued
// character at a time; the queue takes new ones until it is full.
`include "infix_to_postfix_converter_core_macros.svh"

module infix_to_postfix_converter_core #(
  parameter int unsigned QueueDepth = itp_pkg::QUEUE_DEPTH
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  itp_in_if.sink     in_i,
  itp_out_if.source  out_o
);

  itp_pkg::head_t        head;
  logic                  pop;
  itp_pkg::back_status_t status;

  itp_front #(
    .Depth (QueueDepth)
  ) u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .head_o (head),
    .pop_i  (pop)
  );

  itp_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .head_i   (head),
    .pop_o    (pop),
    .out_o    (out_o),
    .status_o (status)
  );

  // back end only retires an item the queue actually holds
  `ITP_ASSERT_NOW(a_pop_has_head, clk_i, rst_ni, pop, head.valid, "pop with empty queue")
  // end of expression is always the end of its run
  `ITP_ASSERT_NOW(a_done_is_last, clk_i, rst_ni, out_o.valid && out_o.expr_done,
                  out_o.last_of_run, "expr_done without last_of_run")
  // a stalled result stays offered and unchanged
  `ITP_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_o.valid && !out_o.ready,
                   out_o.valid && $stable(out_o.out_symbol) && $stable(out_o.last_of_run)
                   && $stable(out_o.expr_done), "result changed while stalled")
  // stack never grows past two entries
  `ITP_ASSERT_NOW(a_stack_bound, clk_i, rst_ni, 1'b1, status.stack_count != 2'd3,
                  "operator stack overflow")

endmodule
